/* sv/wavetable_attack_decay_envelope_top_assert.svh */
// assertion macros for the envelope block checker
// expects clk and rst_n in the scope of each use
`ifndef WAVETABLE_ATTACK_DECAY_ENVELOPE_TOP_ASSERT_SVH
`define WAVETABLE_ATTACK_DECAY_ENVELOPE_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define WTAD_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// consequent required in the cycle after the antecedent
`define WTAD_CHECK_NEXT(label, ante, cons, msg) \
    `WTAD_CHECK(label, (ante) |=> (cons), msg)

`endif

/* sv/wtad_pkg.sv */
// shared constants, shape table and register codes for the envelope block
// no dependencies
`default_nettype none

package wtad_pkg;

    localparam int TABLE_ENTRIES_DEF   = 16;
    localparam int PHASE_FRAC_BITS_DEF = 24;
    localparam int ROM_ENTRIES         = 16;

    localparam int INC_W      = 28;
    localparam int MORPH_W    = 9;
    localparam int MORPH_FRAC = 8;
    localparam int LEVEL_W    = 16;
    localparam int DIFF_W     = 18;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - LEVEL_W - 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MORPH  = 2'd2;

    localparam logic [INC_W-1:0]   ATTACK_RESET = 28'd5592;
    localparam logic [INC_W-1:0]   DECAY_RESET  = 28'd5592;
    localparam logic [LEVEL_W-1:0] LEVEL_MASK   = 16'hFFF0;

    // row 0 sine slope, row 1 ramp, 12-bit entries
    function automatic logic [11:0] shape_rom(input logic row, input logic [3:0] r);
        logic [11:0] v;
        if (!row)
        begin
            case (r)
                4'd0:    v = 12'd0;
                4'd1:    v = 12'd39;
                4'd2:    v = 12'd156;
                4'd3:    v = 12'd345;
                4'd4:    v = 12'd600;
                4'd5:    v = 12'd910;
                4'd6:    v = 12'd1264;
                4'd7:    v = 12'd1648;
                4'd8:    v = 12'd2048;
                4'd9:    v = 12'd2447;
                4'd10:   v = 12'd2831;
                4'd11:   v = 12'd3185;
                4'd12:   v = 12'd3495;
                4'd13:   v = 12'd3750;
                4'd14:   v = 12'd3939;
                default: v = 12'd4056;
            endcase
        end
        else
        begin
            v = {r, 8'd0};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/wtad_serial_mul.sv */
// bit-serial signed-by-unsigned multiplier, one weight bit per cycle
// returns floor(diff * weight / 2^WEIGHT_W); uses wtad_pkg
`default_nettype none

module wtad_serial_mul #(
    parameter int WEIGHT_W = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [wtad_pkg::DIFF_W-1:0] diff,
    input  wire logic [WEIGHT_W-1:0]               weight,
    output logic                                   done,
    output logic signed [wtad_pkg::DIFF_W-1:0]     prod
);
    import wtad_pkg::*;

    localparam int CNT_W = $clog2(WEIGHT_W);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [WEIGHT_W-1:0]      w_reg, w_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [DIFF_W-1:0] acc_reg, acc_next;
    logic signed [DIFF_W-1:0] sum;
    logic                     last;

    assign last = (cnt_reg == CNT_W'(WEIGHT_W - 1));
    assign sum  = acc_reg + (w_reg[0] ? diff_reg : DIFF_W'(0));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        w_next    = w_reg;
        diff_next = diff_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            w_next    = weight;
            diff_next = diff;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // arithmetic shift keeps the floor of the partial product
            acc_next = sum >>> 1;
            w_next   = w_reg >> 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

/* sv/wavetable_attack_decay_envelope_top.sv */
// attack/decay envelope with interpolated, morphed wavetable shapes
// uses wtad_pkg and wtad_serial_mul
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata[0] trigger
// m_*      out  m_tvalid/m_tready   m_tdata[15:0] level, [16] running
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// an idle tick, or a tick with the envelope stopped, leaves the block idle
// a running tick goes through load, the bit-serial interpolation pass and
// the 8-bit serial morph pass before the next tick is taken
// rst_n clears phase, running flag, held level and registers to defaults
// s_tready drops while a level is computed or while m holds an untaken result
// cfg_ready is always high
`default_nettype none

module wavetable_attack_decay_envelope_top #(
    parameter int TABLE_ENTRIES   = wtad_pkg::TABLE_ENTRIES_DEF,
    parameter int PHASE_FRAC_BITS = wtad_pkg::PHASE_FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [wtad_pkg::S_TDATA_W-1:0]   s_tdata,   // trigger, zero pad
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wtad_pkg::M_TDATA_W-1:0]        m_tdata,   // level, running, zero pad
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wtad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wtad_pkg::INC_W-1:0]       cfg_data
);
    import wtad_pkg::*;

    localparam int F   = PHASE_FRAC_BITS;
    localparam int IW1 = $clog2(2 * TABLE_ENTRIES);
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int PW  = IW1 + F;
    localparam int SW  = ((PW > INC_W) ? PW : INC_W) + 1;

    localparam logic [PW-1:0] KNEE   = PW'(TABLE_ENTRIES - 1) << F;
    localparam logic [PW-1:0] MIRROR = PW'(2 * (TABLE_ENTRIES - 1)) << F;
    localparam logic [PW-1:0] ENDP   = PW'(2 * TABLE_ENTRIES - 1) << F;
    localparam logic [PW:0]   PMAX_W = ((PW + 1)'(2 * TABLE_ENTRIES) << F) - 1'b1;
    localparam logic [PW-1:0] PMAX   = PMAX_W[PW-1:0];
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_INTERP = 2'd2;
    localparam logic [1:0] ST_MORPH  = 2'd3;

    // shape tables scaled by 16
    logic [LEVEL_W-1:0] sine_tab [TABLE_ENTRIES];
    logic [LEVEL_W-1:0] ramp_tab [TABLE_ENTRIES];

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_tab
        localparam int R = (i * ROM_ENTRIES) / TABLE_ENTRIES;
        assign sine_tab[i] = {shape_rom(1'b0, 4'(R)), 4'd0};
        assign ramp_tab[i] = {shape_rom(1'b1, 4'(R)), 4'd0};
    end

    logic [1:0]         state_reg, state_next;
    logic [INC_W-1:0]   attack_reg, decay_reg;
    logic [MORPH_W-1:0] morph_reg;
    logic [PW-1:0]      phase_reg, phase_next;
    logic               active_reg, active_next;
    logic [LEVEL_W-1:0] held_reg, held_next;
    logic               m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic               out_run_reg, out_run_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [LEVEL_W-1:0] a_s_reg, a_s_next;
    logic [LEVEL_W-1:0] a_r_reg, a_r_next;
    logic [LEVEL_W-1:0] s_val_reg, s_val_next;
    logic [LEVEL_W-1:0] r_val_reg, r_val_next;

    logic               in_acc;
    logic               trigger;
    logic               run_eff;
    logic [PW-1:0]      ph_cur;
    logic               attack;
    logic [INC_W-1:0]   inc;
    logic [SW-1:0]      ph_sum;
    logic [PW-1:0]      ph_sat;
    logic               finished;
    logic [PW-1:0]      pos_calc;

    logic [IW1-1:0]     idx_full;
    logic [IW-1:0]      idx, nb;
    logic [LEVEL_W-1:0] b_s, b_r;

    logic                     start_i, start_m;
    logic signed [DIFF_W-1:0] diff_s, diff_r, diff_m;
    logic signed [DIFF_W-1:0] prod_s, prod_r, prod_m;
    logic                     done_s, done_r, done_m;
    logic signed [DIFF_W-1:0] s_sum, r_sum, v_sum;
    logic [MORPH_FRAC-1:0]    m_weight;

    assign cfg_ready = 1'b1;
    assign trigger   = s_tdata[0];
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign in_acc    = s_tvalid && s_tready;

    // phase step
    assign run_eff  = active_reg || trigger;
    assign ph_cur   = active_reg ? phase_reg : '0;
    assign attack   = (ph_cur <= KNEE);
    assign inc      = attack ? attack_reg : decay_reg;
    assign ph_sum   = SW'(ph_cur) + SW'(inc);
    assign ph_sat   = (ph_sum > SW'(PMAX)) ? PMAX : ph_sum[PW-1:0];
    assign finished = (ph_sat >= ENDP);
    assign pos_calc = attack ? ph_sat : ((ph_sat <= MIRROR) ? (MIRROR - ph_sat) : '0);

    // table index and neighbor, both clamped to the last entry
    assign idx_full = pos_reg[PW-1:F];
    assign idx      = (idx_full > IW1'(TABLE_ENTRIES - 1)) ? LAST_IDX : idx_full[IW-1:0];
    assign nb       = (idx == LAST_IDX) ? idx : idx + IW'(1);
    assign b_s      = sine_tab[nb];
    assign b_r      = ramp_tab[nb];
    assign a_s_next = (state_reg == ST_LOAD) ? sine_tab[idx] : a_s_reg;
    assign a_r_next = (state_reg == ST_LOAD) ? ramp_tab[idx] : a_r_reg;

    assign diff_s  = $signed({2'b00, b_s}) - $signed({2'b00, sine_tab[idx]});
    assign diff_r  = $signed({2'b00, b_r}) - $signed({2'b00, ramp_tab[idx]});
    assign start_i = (state_reg == ST_LOAD);

    assign s_sum   = $signed({2'b00, a_s_reg}) + prod_s;
    assign r_sum   = $signed({2'b00, a_r_reg}) + prod_r;
    assign diff_m  = r_sum - s_sum;
    assign start_m = (state_reg == ST_INTERP) && done_s;

    assign m_weight = morph_reg[MORPH_W-1] ? '0 : morph_reg[MORPH_FRAC-1:0];
    assign v_sum    = $signed({2'b00, s_val_reg}) + prod_m;

    wtad_serial_mul #(.WEIGHT_W(F)) u_mul_sine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_i),
        .diff   (diff_s),
        .weight (pos_reg[F-1:0]),
        .done   (done_s),
        .prod   (prod_s)
    );

    wtad_serial_mul #(.WEIGHT_W(F)) u_mul_ramp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_i),
        .diff   (diff_r),
        .weight (pos_reg[F-1:0]),
        .done   (done_r),
        .prod   (prod_r)
    );

    wtad_serial_mul #(.WEIGHT_W(MORPH_FRAC)) u_mul_morph (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_m),
        .diff   (diff_m),
        .weight (m_weight),
        .done   (done_m),
        .prod   (prod_m)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        active_next    = active_reg;
        held_next      = held_reg;
        m_valid_next   = m_valid_reg;
        out_level_next = out_level_reg;
        out_run_next   = out_run_reg;
        pos_next       = pos_reg;
        s_val_next     = s_val_reg;
        r_val_next     = r_val_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    m_valid_next   = 1'b1;
                    out_level_next = held_reg;
                    if (run_eff)
                    begin
                        phase_next   = finished ? '0 : ph_sat;
                        active_next  = !finished;
                        out_run_next = !finished;
                        pos_next     = pos_calc;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        out_run_next = 1'b0;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                if (done_s && done_r)
                begin
                    s_val_next = s_sum[LEVEL_W-1:0];
                    r_val_next = r_sum[LEVEL_W-1:0];
                    state_next = ST_MORPH;
                end
            end
            ST_MORPH:
            begin
                if (done_m)
                begin
                    // full morph takes the ramp value as it is
                    held_next  = (morph_reg[MORPH_W-1] ? r_val_reg : v_sum[LEVEL_W-1:0])
                                 & LEVEL_MASK;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            active_reg  <= 1'b0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            attack_reg  <= ATTACK_RESET;
            decay_reg   <= DECAY_RESET;
            morph_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ATTACK: attack_reg <= cfg_data;
                    CFG_DECAY:  decay_reg  <= cfg_data;
                    CFG_MORPH:  morph_reg  <= cfg_data[MORPH_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_level_reg <= out_level_next;
        out_run_reg   <= out_run_next;
        pos_reg       <= pos_next;
        a_s_reg       <= a_s_next;
        a_r_reg       <= a_r_next;
        s_val_reg     <= s_val_next;
        r_val_reg     <= r_val_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_run_reg, out_level_reg};

endmodule

`default_nettype wire

/* sv/wtad_checker.sv */
// port-level checker for the envelope block, bound to the top level
// uses wtad_pkg and wavetable_attack_decay_envelope_top_assert.svh
`default_nettype none

module wtad_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [wtad_pkg::M_TDATA_W-1:0]   m_tdata
);
    import wtad_pkg::*;

`include "wavetable_attack_decay_envelope_top_assert.svh"

    // level is left-aligned, low nibble never set
    `WTAD_CHECK(a_level_low_zero, m_tvalid |-> (m_tdata[3:0] == 4'd0), "level low bits set")

    // padding above running stays zero
    `WTAD_CHECK(a_pad_zero, m_tvalid |-> (m_tdata[M_TDATA_W-1:LEVEL_W+1] == '0), "pad bits set")

    // every accepted tick yields one result transaction
    `WTAD_CHECK_NEXT(a_tick_gives_result, s_tvalid && s_tready, m_tvalid, "no result after tick")

    // a stalled result holds
    `WTAD_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed")

endmodule

bind wavetable_attack_decay_envelope_top wtad_checker u_wtad_checker (.*);

`default_nettype wire
